// ===== src/avtm_pkg.sv =====
//------------------------------------------------------------------------------
// avtm_pkg
// Shared types, opcodes and constants of the timestamp mapper.
//------------------------------------------------------------------------------
package avtm_pkg;

	typedef enum logic [2:0] {
		OP_VIDEO      = 3'd0,
		OP_AUDIO      = 3'd1,
		OP_SUB        = 3'd2,
		OP_VDISCONT   = 3'd3,
		OP_ADISCONT   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		REG_AUDIO_PRESENT = 3'd0,
		REG_TICKS         = 3'd1,
		REG_LIP           = 3'd2,
		REG_JUMP          = 3'd3,
		REG_DRIFT         = 3'd4,
		REG_MISMATCH      = 3'd5,
		REG_DELTA         = 3'd6
	} reg_idx_t;

	localparam logic [63:0] PREBUFFER   = 64'd30000;
	localparam logic [23:0] JUMP_RST    = 24'd120000;
	localparam logic [23:0] DRIFT_RST   = 24'd45000;
	localparam logic [7:0]  MISM_RST    = 8'd10;
	localparam logic [15:0] DELTA_RST   = 16'd1600;
	localparam int          DIV_BITS    = 48;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_VID_A,
		ST_VID_B,
		ST_AUD_A,
		ST_AUD_MUL,
		ST_AUD_DIV,
		ST_AUD_ACC,
		ST_AUD_ADV,
		ST_AUD_FIN,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic vid_a;
		logic vid_b;
		logic aud_a;
		logic aud_mul;
		logic div_start;
		logic aud_acc;
		logic aud_adv;
		logic aud_fin;
		logic sub;
		logic vdisc;
		logic adisc;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       div_done;
		logic       need_div;
		logic [2:0] op;
	} sts_t;

	function automatic logic s_gt(input logic [63:0] a, input logic [63:0] b);
		return $signed(a) > $signed(b);
	endfunction

	function automatic logic [63:0] mag(input logic [63:0] a);
		return a[63] ? (64'd0 - a) : a;
	endfunction

	function automatic logic [63:0] sext32(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

endpackage

// ===== src/av_timestamp_mapper.sv =====
//------------------------------------------------------------------------------
// av_timestamp_mapper
// Top level: maps stream timestamps of video, audio and subpicture words to
// presentation time.
//------------------------------------------------------------------------------
// One word at a time. Discontinuity words give no result; audio words run
// the rate correction, when it applies, on the 48-step serial divider. A
// finished result sits in an output register; the next word is taken right
// away and only its own result waits, in its last step, until that register
// has been emptied.
module av_timestamp_mapper
	import avtm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [2:0]   opcode,
	input  logic [32:0]  stamp,
	input  logic [19:0]  frame_ticks,
	input  logic [15:0]  sample_count,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [63:0]  present_time
);
	cmd_t cmd;
	sts_t sts;

	avtm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	avtm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.opcode       (opcode),
		.stamp        (stamp),
		.frame_ticks  (frame_ticks),
		.sample_count (sample_count),
		.cmd          (cmd),
		.sts          (sts),
		.present_time (present_time)
	);
endmodule

// ===== src/avtm_div.sv =====
//------------------------------------------------------------------------------
// avtm_div
// Radix-2 restoring divider, unsigned, one quotient bit per cycle.
//------------------------------------------------------------------------------
module avtm_div
	import avtm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_BITS-1:0] dividend,
	input  logic [31:0]         divisor,
	output logic [DIV_BITS-1:0] quotient,
	output logic                done
);
	localparam int CW = $clog2(DIV_BITS + 1);

	logic [DIV_BITS-1:0] quo_q;
	logic [32:0]         rem_q;
	logic [31:0]         dvs_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q;
	logic [32:0]         trial;
	logic [32:0]         diff;

	assign trial = {rem_q[31:0], quo_q[DIV_BITS-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff;
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

// ===== src/avtm_ctrl.sv =====
//------------------------------------------------------------------------------
// avtm_ctrl
// Sequencer: steps one word through the datapath and drives the handshakes.
//------------------------------------------------------------------------------
module avtm_ctrl
	import avtm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;
	logic   ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	assign out_valid = ov_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				priority case (sts.op)
					OP_VIDEO: state_d = ST_VID_A;
					OP_AUDIO: state_d = ST_AUD_A;
					OP_SUB: begin
						cmd.sub = 1'b1;
						state_d = ST_OUT;
					end
					OP_VDISCONT: begin
						cmd.vdisc = 1'b1;
						state_d   = ST_IDLE;
					end
					OP_ADISCONT: begin
						cmd.adisc = 1'b1;
						state_d   = ST_IDLE;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_VID_A: begin
				cmd.vid_a = 1'b1;
				state_d   = ST_VID_B;
			end
			ST_VID_B: begin
				cmd.vid_b = 1'b1;
				state_d   = ST_OUT;
			end
			ST_AUD_A: begin
				cmd.aud_a = 1'b1;
				state_d   = ST_AUD_MUL;
			end
			ST_AUD_MUL: begin
				cmd.aud_mul = 1'b1;
				if (sts.need_div) begin
					cmd.div_start = 1'b1;
					state_d       = ST_AUD_DIV;
				end else begin
					state_d = ST_AUD_ADV;
				end
			end
			ST_AUD_DIV: if (sts.div_done) state_d = ST_AUD_ACC;
			ST_AUD_ACC: begin
				cmd.aud_acc = 1'b1;
				state_d     = ST_AUD_ADV;
			end
			ST_AUD_ADV: begin
				cmd.aud_adv = 1'b1;
				state_d     = ST_AUD_FIN;
			end
			ST_AUD_FIN: begin
				cmd.aud_fin = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (!ov_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== src/avtm_dp.sv =====
//------------------------------------------------------------------------------
// avtm_dp
// Datapath: clock, wrap and rate state plus the arithmetic for each word.
//------------------------------------------------------------------------------
module avtm_dp
	import avtm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic [2:0]   opcode,
	input  logic [32:0]  stamp,
	input  logic [19:0]  frame_ticks,
	input  logic [15:0]  sample_count,
	input  cmd_t         cmd,
	output sts_t         sts,
	output logic [63:0]  present_time
);
	// configuration
	logic        audio_present_q;
	logic [23:0] ticks_q, jump_q, drift_q;
	logic [31:0] lip_q;
	logic [7:0]  mism_lim_q;
	logic [15:0] delta_lim_q;

	// state
	logic [63:0] vclk_q, aclk_q, vwrap_q, awrap_q;
	logic [63:0] pvs_q;
	logic [32:0] pas_q, pss_q;
	logic [31:0] rdelta_q, sss_q;
	logic [7:0]  mcnt_q;
	logic        vpend_q, apend_q;
	logic [3:0]  bal_q;

	// item and scratch
	logic [2:0]  op_q;
	logic [32:0] stamp_q;
	logic [19:0] dur_q;
	logic [15:0] n_q;
	logic [63:0] res_q, vpts_q, tmp_q;
	logic        upd_q, neg_q;
	logic [63:0] out_q;
	logic [63:0] a_mag;

	logic [DIV_BITS-1:0] quo;
	logic                div_done;

	avtm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (a_mag[DIV_BITS-1:0]),
		.divisor  (sss_q),
		.quotient (quo),
		.done     (div_done)
	);

	assign sts.div_done = div_done;
	assign sts.need_div = upd_q;
	assign sts.op       = op_q;
	assign present_time = out_q;

	// wrap check shared by video and audio
	logic        wc_act, wc_force;
	logic [7:0]  wc_cnt;
	always_comb begin
		wc_act   = (vwrap_q != awrap_q) && !vpend_q && !apend_q;
		wc_cnt   = (mcnt_q != 8'hff) ? mcnt_q + 8'd1 : mcnt_q;
		wc_force = wc_act && (wc_cnt > mism_lim_q);
	end
	logic [63:0] wrap_max;
	assign wrap_max = s_gt(vwrap_q, awrap_q) ? vwrap_q : awrap_q;
	logic [63:0] clk_max;
	assign clk_max = s_gt(vclk_q, aclk_q) ? vclk_q : aclk_q;

	// video combinational pieces
	logic        v_jump, v_zero;
	logic [63:0] v_d;
	always_comb begin
		v_d    = {31'd0, stamp_q} - (pvs_q + {44'd0, dur_q});
		v_jump = (stamp_q != '0) && (mag(v_d) > {40'd0, jump_q});
		v_zero = (stamp_q == '0) || (v_jump && !vpend_q);
	end
	logic [63:0] vb_vpts, vb_d, vb_new;
	always_comb begin
		vb_vpts = {31'd0, stamp_q} + vwrap_q;
		vb_d    = vclk_q - vb_vpts;
		if (mag(vb_d) > {40'd0, drift_q}) vb_new = vb_vpts;
		else vb_new = vclk_q - (vb_d[63] ? (64'd0 - ((64'd0 - vb_d) >> 3)) : (vb_d >> 3));
	end

	// audio
	logic [31:0] a_err;
	logic [63:0] a_prod, a_q64, a_sum, a_mul;
	logic [31:0] a_rd;
	always_comb begin
		a_err  = vpts_q[31:0] - aclk_q[31:0];
		a_prod = sext32(a_err) << 15;
		a_mag  = mag(a_prod);
		a_q64  = neg_q ? (64'd0 - {16'd0, quo}) : {16'd0, quo};
		a_rd   = rdelta_q + a_q64[31:0];
		a_sum  = sext32(rdelta_q) + {40'd0, ticks_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio_present_q <= 1'b0;
			ticks_q         <= '0;
			lip_q           <= '0;
			jump_q          <= JUMP_RST;
			drift_q         <= DRIFT_RST;
			mism_lim_q      <= MISM_RST;
			delta_lim_q     <= DELTA_RST;
			vclk_q          <= PREBUFFER;
			aclk_q          <= PREBUFFER;
			vwrap_q         <= PREBUFFER;
			awrap_q         <= PREBUFFER;
			pvs_q           <= '0;
			pas_q           <= '0;
			pss_q           <= '0;
			rdelta_q        <= '0;
			sss_q           <= 32'd1;
			mcnt_q          <= '0;
			vpend_q         <= 1'b0;
			apend_q         <= 1'b0;
			bal_q           <= '0;
			op_q            <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_AUDIO_PRESENT: audio_present_q <= cfg_data[0];
					REG_TICKS:         ticks_q         <= cfg_data[23:0];
					REG_LIP:           lip_q           <= cfg_data;
					REG_JUMP:          jump_q          <= cfg_data[23:0];
					REG_DRIFT:         drift_q         <= cfg_data[23:0];
					REG_MISMATCH:      mism_lim_q      <= cfg_data[7:0];
					REG_DELTA:         delta_lim_q     <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.load) op_q <= opcode;

			// video first step: discontinuity resync, wrap check, or previous stamp rebuilt from the clock
			if (cmd.vid_a) begin
				if (!v_zero && vpend_q && v_jump) begin
					vpend_q <= 1'b0;
					mcnt_q  <= '0;
					vwrap_q <= vclk_q - {31'd0, stamp_q};
					pvs_q   <= {31'd0, stamp_q};
				end else if (!v_zero) begin
					if (audio_present_q && wc_act) begin
						if (wc_force) begin
							mcnt_q  <= '0;
							vwrap_q <= wrap_max;
							awrap_q <= wrap_max;
						end else mcnt_q <= wc_cnt;
					end
					pvs_q <= {31'd0, stamp_q};
				end else begin
					pvs_q <= vclk_q - vwrap_q;
				end
			end
			if (cmd.vid_b) begin
				if (upd_q) begin
					res_q  <= vb_new + sext32(lip_q);
					vclk_q <= vb_new + {44'd0, dur_q};
				end else begin
					res_q  <= vclk_q + sext32(lip_q);
					vclk_q <= vclk_q + {44'd0, dur_q};
				end
			end

			if (cmd.aud_a) begin
				if (stamp_q != '0) begin
					if (apend_q) begin
						apend_q <= 1'b0;
						mcnt_q  <= '0;
						awrap_q <= aclk_q - {31'd0, stamp_q};
						vpts_q  <= aclk_q;
					end else begin
						logic [63:0] aw;
						aw = awrap_q;
						if (wc_act) begin
							if (wc_force) begin
								mcnt_q  <= '0;
								vwrap_q <= wrap_max;
								awrap_q <= wrap_max;
								aw      = wrap_max;
							end else mcnt_q <= wc_cnt;
						end
						vpts_q <= {31'd0, stamp_q} + aw;
					end
				end else begin
					vpts_q <= aclk_q;
				end
			end
			if (cmd.aud_mul) begin
				neg_q <= a_prod[63];
			end
			if (cmd.aud_acc) begin
				if (mag(sext32(a_rd)) >= {48'd0, delta_lim_q}) rdelta_q <= '0;
				else rdelta_q <= a_rd;
			end
			if (cmd.aud_adv) begin
				if (stamp_q != '0) begin
					sss_q  <= '0;
					pas_q  <= stamp_q;
					aclk_q <= vpts_q;
				end
				res_q <= vpts_q;
				tmp_q <= a_mul;
			end
			if (cmd.aud_fin) begin
				aclk_q <= aclk_q + (tmp_q[63] ? (64'd0 - ((64'd0 - tmp_q) >> 15))
				                              : (tmp_q >> 15));
				sss_q  <= sss_q + {16'd0, n_q};
			end

			if (cmd.sub) begin
				logic [32:0] p;
				p = (stamp_q != '0) ? stamp_q : pss_q;
				if (stamp_q != '0) pss_q <= stamp_q;
				if (vpend_q) res_q <= apend_q ? 64'd0 : {31'd0, p} + awrap_q;
				else res_q <= {31'd0, p} + vwrap_q;
			end

			if (cmd.vdisc) begin
				logic [3:0] nb;
				nb = ($signed(bal_q) < 4'sd7) ? bal_q + 4'd1 : bal_q;
				vpend_q <= 1'b1;
				bal_q   <= nb;
				if (audio_present_q && $signed(nb) <= 4'sd0) begin
					aclk_q <= clk_max;
					vclk_q <= clk_max;
				end
			end
			if (cmd.adisc) begin
				logic [3:0] nb;
				nb = ($signed(bal_q) > -4'sd8) ? bal_q - 4'd1 : bal_q;
				apend_q <= 1'b1;
				bal_q   <= nb;
				if ($signed(nb) >= 4'sd0) begin
					aclk_q <= clk_max;
					if (audio_present_q) vclk_q <= clk_max;
				end
			end
		end
	end

	// product for the clock advance, registered before use
	assign a_mul = a_sum * {48'd0, n_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			stamp_q <= stamp;
			dur_q   <= frame_ticks;
			n_q     <= sample_count;
		end
		if (cmd.vid_a) upd_q <= !v_zero && !(vpend_q && v_jump);
		if (cmd.aud_a) upd_q <= (stamp_q != '0) && !apend_q && (pas_q != '0)
			&& (stamp_q > pas_q) && (sss_q != '0);
		if (cmd.out_load) out_q <= res_q;
	end
endmodule

// ===== src/avtm_checker.sv =====
//------------------------------------------------------------------------------
// avtm_checker
// Port-level checks of the timestamp mapper, bound to the top level.
//------------------------------------------------------------------------------
module avtm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] present_time
);
	// a word is never taken in the cycle right after another
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("back to back accept");

	// a held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(present_time))
		else $error("result changed while stalled");

	// a result is loaded only while a word is being worked on
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without work");
endmodule

bind av_timestamp_mapper avtm_checker u_avtm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.present_time (present_time)
);
